// ===== rtl/core/cle_pkg.sv =====
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types and constants for the character LCD command engine.
// ----------------------------------------------------------------------------
package cle_pkg;

  // command codes on the func field
  localparam logic [3:0] FUNC_INIT   = 4'd0;
  localparam logic [3:0] FUNC_PUTC   = 4'd1;
  localparam logic [3:0] FUNC_MOVE   = 4'd2;
  localparam logic [3:0] FUNC_CLEAR  = 4'd3;
  localparam logic [3:0] FUNC_ON     = 4'd4;
  localparam logic [3:0] FUNC_OFF    = 4'd5;
  localparam logic [3:0] FUNC_SHOW   = 4'd6;
  localparam logic [3:0] FUNC_HIDE   = 4'd7;
  localparam logic [3:0] FUNC_GLYPH  = 4'd8;

  // register indexes
  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  localparam int CFG_DATA_W = 6;

  // controller instruction bytes
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_ENTRY    = 8'h06;
  localparam logic [7:0] CMD_DISP     = 8'h08;
  localparam logic [7:0] CMD_FUNC_SET = 8'h20;
  localparam logic [7:0] FUNC_2LINE   = 8'h08;
  localparam logic [7:0] CMD_CGRAM    = 8'h40;
  localparam logic [7:0] CMD_DDRAM    = 8'h80;

  // display flag bits
  localparam int FLAG_ON     = 2;
  localparam int FLAG_CURSOR = 1;
  localparam int FLAG_BLINK  = 0;

  // waits in microseconds
  localparam logic [12:0] WAIT_NONE  = 13'd0;
  localparam logic [12:0] WAIT_SHORT = 13'd37;
  localparam logic [12:0] WAIT_HOME  = 13'd1520;
  localparam logic [12:0] WAIT_CLEAR = 13'd4000;
  localparam logic [12:0] WAIT_POR   = 13'd4100;
  localparam logic [12:0] WAIT_POR2  = 13'd100;

  localparam logic [3:0] NIB_WAKE  = 4'h3;
  localparam logic [3:0] NIB_4BIT  = 4'h2;
  localparam logic [3:0] WAKE_NIBS = 4'd5;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef struct packed {
    logic [3:0] func;
    logic [7:0] char_code;
    logic [5:0] col;
    logic [1:0] row;
    logic       blink;
    logic [2:0] glyph_id;
    logic [2:0] glyph_line;
    logic [7:0] glyph_bits;
  } cmd_t;

  typedef struct packed {
    logic        rs;
    logic [3:0]  nibble;
    logic [12:0] wait_us;
    logic        last;
  } nib_t;

  typedef struct packed {
    logic       rs;
    logic [7:0] value;
  } lcd_byte_t;

  // one classified command: optional wake-up prefix plus one to four bytes
  typedef struct packed {
    logic                  wake;
    logic [1:0]            n_m1;
    lcd_byte_t [3:0]       bytes;
  } job_t;

  function automatic logic [6:0] row_offset(input logic [1:0] r);
    logic [6:0] o;
    case (r)
      2'd0:    o = 7'h00;
      2'd1:    o = 7'h40;
      2'd2:    o = 7'h14;
      2'd3:    o = 7'h54;
      default: o = 7'h00;
    endcase
    return o;
  endfunction

  function automatic logic [7:0] ddram_cmd(input logic [5:0] c, input logic [1:0] r);
    logic [6:0] a;
    a = {1'b0, c} + row_offset(r);
    return CMD_DDRAM | {1'b0, a};
  endfunction

endpackage

// ===== rtl/core/cle_front.sv =====
// ----------------------------------------------------------------------------
// cle_front
// Accepts command words, tracks cursor and display flags, builds byte jobs.
// ----------------------------------------------------------------------------
module cle_front #(
  parameter int MAX_ROWS    = 4,
  parameter int MAX_COLUMNS = 40
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [cle_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  cle_pkg::cmd_t                 cmd_word,
  input  logic                          q_full,
  output logic                          push,
  output cle_pkg::job_t                 push_job
);

  localparam int CLAMP_COLS = (MAX_COLUMNS > 63) ? 63 : MAX_COLUMNS;

  logic [5:0] columns;
  logic [2:0] rows;
  logic [1:0] cursor_row, cursor_row_next;
  logic [5:0] cursor_col, cursor_col_next;
  logic [2:0] flags, flags_next;

  logic [5:0] eff_cols;
  logic [2:0] eff_rows;
  logic [6:0] col_inc;
  logic [2:0] row_inc;
  logic [1:0] wrap_row;
  logic       known;
  logic       accept;

  assign cmd_stall = q_full;
  assign accept    = cmd_valid && !cmd_stall;

  always_comb begin
    if (columns == 6'd0) begin
      eff_cols = 6'd1;
    end else if (columns > 6'(CLAMP_COLS)) begin
      eff_cols = 6'(CLAMP_COLS);
    end else begin
      eff_cols = columns;
    end
    if (rows == 3'd0) begin
      eff_rows = 3'd1;
    end else if (rows > 3'(MAX_ROWS)) begin
      eff_rows = 3'(MAX_ROWS);
    end else begin
      eff_rows = rows;
    end
    col_inc  = {1'b0, cursor_col} + 7'd1;
    row_inc  = {1'b0, cursor_row} + 3'd1;
    wrap_row = (row_inc >= eff_rows) ? 2'd0 : row_inc[1:0];
  end

  always_comb begin
    cursor_row_next = cursor_row;
    cursor_col_next = cursor_col;
    flags_next      = flags;
    known           = 1'b1;
    push_job        = '0;
    case (cmd_word.func)
      cle_pkg::FUNC_INIT: begin
        push_job.wake     = 1'b1;
        push_job.n_m1     = 2'd3;
        push_job.bytes[0] = {1'b0, cle_pkg::CMD_FUNC_SET |
                             ((eff_rows > 3'd1) ? cle_pkg::FUNC_2LINE : 8'h00)};
        push_job.bytes[1] = {1'b0, cle_pkg::CMD_DISP | {5'd0, flags}};
        push_job.bytes[2] = {1'b0, cle_pkg::CMD_ENTRY};
        push_job.bytes[3] = {1'b0, cle_pkg::CMD_CLEAR};
        cursor_row_next   = 2'd0;
        cursor_col_next   = 6'd0;
      end
      cle_pkg::FUNC_PUTC: begin
        push_job.bytes[0] = {1'b1, cmd_word.char_code};
        if (col_inc >= {1'b0, eff_cols}) begin
          // past the last column: next row, rewrite the address
          push_job.n_m1     = 2'd1;
          push_job.bytes[1] = {1'b0, cle_pkg::ddram_cmd(6'd0, wrap_row)};
          cursor_col_next   = 6'd0;
          cursor_row_next   = wrap_row;
        end else begin
          cursor_col_next = col_inc[5:0];
        end
      end
      cle_pkg::FUNC_MOVE: begin
        push_job.bytes[0] = {1'b0, cle_pkg::ddram_cmd(cmd_word.col, cmd_word.row)};
        cursor_col_next   = cmd_word.col;
        cursor_row_next   = cmd_word.row;
      end
      cle_pkg::FUNC_CLEAR: begin
        push_job.bytes[0] = {1'b0, cle_pkg::CMD_CLEAR};
        cursor_row_next   = 2'd0;
        cursor_col_next   = 6'd0;
      end
      cle_pkg::FUNC_ON, cle_pkg::FUNC_OFF, cle_pkg::FUNC_SHOW, cle_pkg::FUNC_HIDE: begin
        if (cmd_word.func == cle_pkg::FUNC_ON) begin
          flags_next[cle_pkg::FLAG_ON] = 1'b1;
        end else if (cmd_word.func == cle_pkg::FUNC_OFF) begin
          flags_next[cle_pkg::FLAG_ON] = 1'b0;
        end else if (cmd_word.func == cle_pkg::FUNC_SHOW) begin
          flags_next[cle_pkg::FLAG_CURSOR] = 1'b1;
          flags_next[cle_pkg::FLAG_BLINK]  = flags[cle_pkg::FLAG_BLINK] | cmd_word.blink;
        end else begin
          flags_next[cle_pkg::FLAG_CURSOR] = 1'b0;
          flags_next[cle_pkg::FLAG_BLINK]  = 1'b0;
        end
        push_job.bytes[0] = {1'b0, cle_pkg::CMD_DISP | {5'd0, flags_next}};
      end
      cle_pkg::FUNC_GLYPH: begin
        push_job.bytes[0] = {1'b0, cle_pkg::CMD_CGRAM |
                             {2'b00, cmd_word.glyph_id, cmd_word.glyph_line}};
        push_job.bytes[1] = {1'b1, cmd_word.glyph_bits};
        push_job.bytes[2] = {1'b0, cle_pkg::ddram_cmd(cursor_col, cursor_row)};
        push_job.n_m1     = (cmd_word.glyph_line == 3'd7) ? 2'd2 : 2'd1;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  assign push = accept && known;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns    <= 6'd8;
      rows       <= 3'd2;
      cursor_row <= 2'd0;
      cursor_col <= 6'd0;
      flags      <= 3'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          cle_pkg::REG_COLUMNS: columns <= cfg_data;
          cle_pkg::REG_ROWS:    rows    <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (accept) begin
        cursor_row <= cursor_row_next;
        cursor_col <= cursor_col_next;
        flags      <= flags_next;
      end
    end
  end

endmodule

// ===== rtl/core/cle_queue.sv =====
// ----------------------------------------------------------------------------
// cle_queue
// Small job queue between the front and the nibble sequencer.
// ----------------------------------------------------------------------------
module cle_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cle_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output cle_pkg::job_t head
);

  cle_pkg::job_t slots [cle_pkg::QUEUE_DEPTH];
  logic [cle_pkg::QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [cle_pkg::QUEUE_AW:0]   count;

  assign full  = (count == (cle_pkg::QUEUE_AW+1)'(cle_pkg::QUEUE_DEPTH));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/cle_back.sv =====
// ----------------------------------------------------------------------------
// cle_back
// Walks the head job one nibble per cycle into the output register while the bus does not stall.
// ----------------------------------------------------------------------------
module cle_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  cle_pkg::job_t head,
  output logic          pop,
  output logic          bus_valid,
  input  logic          bus_stall,
  output cle_pkg::nib_t bus_word
);

  logic [3:0]        step;
  logic [3:0]        k;
  logic              in_wake;
  logic              emit;
  cle_pkg::lcd_byte_t cur;
  cle_pkg::nib_t     nib;

  always_comb begin
    in_wake = head.wake && (step < cle_pkg::WAKE_NIBS);
    k       = head.wake ? (step - cle_pkg::WAKE_NIBS) : step;
    cur     = head.bytes[k[2:1]];
    nib     = '0;
    if (in_wake) begin
      nib.rs     = 1'b0;
      nib.nibble = (step == 4'd4) ? cle_pkg::NIB_4BIT : cle_pkg::NIB_WAKE;
      case (step)
        4'd0, 4'd1: nib.wait_us = cle_pkg::WAIT_POR;
        4'd2:       nib.wait_us = cle_pkg::WAIT_POR2;
        default:    nib.wait_us = cle_pkg::WAIT_NONE;
      endcase
    end else begin
      nib.rs = cur.rs;
      if (!k[0]) begin
        nib.nibble  = cur.value[7:4];
        nib.wait_us = cle_pkg::WAIT_NONE;
      end else begin
        nib.nibble = cur.value[3:0];
        if (!cur.rs && cur.value == cle_pkg::CMD_CLEAR) begin
          nib.wait_us = cle_pkg::WAIT_CLEAR;
        end else if (!cur.rs && cur.value[7:1] == 7'h01) begin
          nib.wait_us = cle_pkg::WAIT_HOME;
        end else begin
          nib.wait_us = cle_pkg::WAIT_SHORT;
        end
        nib.last = (k[2:1] == head.n_m1);
      end
    end
  end

  assign emit = q_valid && (!bus_valid || !bus_stall);
  assign pop  = emit && nib.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= 4'd0;
      bus_valid <= 1'b0;
    end else begin
      if (emit) begin
        step      <= nib.last ? 4'd0 : step + 4'd1;
        bus_valid <= 1'b1;
      end else if (!bus_stall) begin
        bus_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      bus_word <= nib;
    end
  end

endmodule

// ===== rtl/core/char_lcd_command_engine.sv =====
// ----------------------------------------------------------------------------
// char_lcd_command_engine
// Character LCD command engine for a 4-bit bus: commands in, nibbles out.
// ----------------------------------------------------------------------------
// Each command word (init, put char, move cursor, clear, display on/off,
// show/hide cursor, glyph line) is taken by the front, which updates the
// cursor and display flags and queues a job of one to four bytes (init
// adds a five-nibble wake-up prefix). The back emits one nibble per cycle
// while the bus does not stall, high nibble first, each with RS, its
// following wait in us and a last mark on the final nibble of the command.
// A command therefore costs two nibbles per byte on the nibble port: 2 for
// most commands, 4 for a wrapping put char or glyph line, 6 for glyph line
// 7 and 13 for init. The nibble port is the limit; a four-entry job queue
// lets new commands come in while earlier ones are still going out, and
// the command side only stalls when that queue is full. Unknown func codes
// are taken and dropped. Registers: index 0 columns (reset 8), index 1
// rows (reset 2); write only while idle.
// ----------------------------------------------------------------------------
module char_lcd_command_engine #(
  parameter int MAX_ROWS    = 4,
  parameter int MAX_COLUMNS = 40
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [cle_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           cmd_valid,
  output logic                           cmd_stall,
  input  cle_pkg::cmd_t                  cmd_word,
  output logic                           bus_valid,
  input  logic                           bus_stall,
  output cle_pkg::nib_t                  bus_word
);

  logic          q_full;
  logic          q_valid;
  logic          push;
  logic          pop;
  cle_pkg::job_t push_job;
  cle_pkg::job_t head;

  // front: classify the word, keep cursor/flags, build the byte job
  cle_front #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_word  (cmd_word),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  // decoupling queue
  cle_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .valid    (q_valid),
    .head     (head)
  );

  // back: nibble sequencer with registered output
  cle_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .bus_valid (bus_valid),
    .bus_stall (bus_stall),
    .bus_word  (bus_word)
  );

`ifndef SYNTHESIS
  // data nibbles never carry the long instruction waits
  a_data_wait: assert property (@(posedge clk) disable iff (rst)
    bus_valid && bus_word.rs |-> bus_word.wait_us == cle_pkg::WAIT_NONE ||
                                 bus_word.wait_us == cle_pkg::WAIT_SHORT)
    else $error("data nibble with instruction wait");

  // a new nibble only shows up when a job was queued
  a_nib_from_job: assert property (@(posedge clk) disable iff (rst)
    $rose(bus_valid) |-> $past(q_valid))
    else $error("nibble without queued job");

  // every accepted known command leaves work in the queue
  a_cmd_queued: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall && cmd_word.func <= cle_pkg::FUNC_GLYPH |=> q_valid)
    else $error("accepted command not queued");
`endif

endmodule
